// File: rtl/geli_pkg.sv
// Package for the GPIO edge/level interrupt register block.
// Beat types, command codes and register indexes. No dependencies.
package geli_pkg;

   localparam logic [1:0] CMD_READ  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_EVENT = 2'd2;

   localparam logic [3:0] REG_DIR  = 4'd0;
   localparam logic [3:0] REG_OUT  = 4'd1;
   localparam logic [3:0] REG_IN   = 4'd2;
   localparam logic [3:0] REG_IE   = 4'd3;
   localparam logic [3:0] REG_IS   = 4'd4;
   localparam logic [3:0] REG_TRIG = 4'd5;
   localparam logic [3:0] REG_POL  = 4'd6;

   typedef struct packed {
      logic [1:0]  command;
      logic [3:0]  reg_index;
      logic [31:0] write_data;
   } req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        bad_address;
      logic [31:0] pin_levels;
      logic        irq;
   } rsp_type;

endpackage

// File: rtl/gpio_edge_level_interrupt_regs.sv
// GPIO edge/level interrupt register block, top level.
// Depends on geli_pkg and geli_regfile.
//
// Each request beat (bus read, bus write or pin-change event) produces one
// response beat. The block takes one request per cycle while the response
// side is ready. A beat is held in a request register, executed against the
// register file and captured in a response register, which drives the
// response outputs until the response side takes the beat. With
// the response side ready, requests can follow back to back. A stalled
// response holds the response register, and one more request can wait in
// the request register before the request side stalls. The response carries
// read data, an invalid-index flag, the driven pin levels and the interrupt
// line as they stand after the beat.
module gpio_edge_level_interrupt_regs import geli_pkg::*; #(
   parameter int PIN_COUNT = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   logic    s1_valid_ff, s1_valid_in;
   req_type s1_req_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff;
   rsp_type rsp_in;
   logic    advance;

   assign advance      = !rsp_valid_ff || rsp_ready;
   assign req_ready    = !s1_valid_ff || advance;
   assign s1_valid_in  = advance ? req_valid : (s1_valid_ff || req_valid);
   assign rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;

   geli_regfile #(.PIN_COUNT(PIN_COUNT)) u_regfile (
      .clock (clock),
      .reset (reset),
      .exec  (advance && s1_valid_ff),
      .req   (s1_req_ff),
      .rsp   (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_req_ff <= req_payload;
      end
      if (advance && s1_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// File: rtl/geli_regfile.sv
// Register file and interrupt update logic of the GPIO block.
// Depends on geli_pkg. Result beat is combinational from state and request.
module geli_regfile import geli_pkg::*; #(
   parameter int PIN_COUNT = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    exec,
   input  req_type req,
   output rsp_type rsp
);

   localparam logic [31:0] PinMask = 32'((64'd1 << PIN_COUNT) - 64'd1);

   logic [31:0] dir_ff, out_ff, inp_ff, ie_ff, is_ff, trig_ff, pol_ff;
   logic [31:0] dir_in, out_in, inp_in, ie_in, is_in, trig_in, pol_in;

   logic [31:0] rd;
   logic        bad;
   logic        upd;
   logic [31:0] is_wr, cur, rise, fall, edge_hit, level_hit;

   always_comb begin
      dir_in  = dir_ff;
      out_in  = out_ff;
      ie_in   = ie_ff;
      is_wr   = is_ff;
      trig_in = trig_ff;
      pol_in  = pol_ff;
      rd      = 32'd0;
      bad     = 1'b0;
      upd     = 1'b0;
      case (req.command)
         CMD_READ: begin
            case (req.reg_index)
               REG_DIR:  rd = dir_ff;
               REG_OUT:  rd = out_ff;
               REG_IN:   rd = inp_ff;
               REG_IE:   rd = ie_ff;
               REG_IS:   rd = is_ff;
               REG_TRIG: rd = trig_ff;
               REG_POL:  rd = pol_ff;
               default:  bad = 1'b1;
            endcase
         end
         CMD_WRITE: begin
            upd = 1'b1;
            case (req.reg_index)
               REG_DIR:  dir_in  = req.write_data;
               REG_OUT:  out_in  = req.write_data;
               REG_IN:   ;
               REG_IE:   ie_in   = req.write_data;
               REG_IS:   is_wr   = is_ff & ~req.write_data;
               REG_TRIG: trig_in = req.write_data;
               REG_POL:  pol_in  = req.write_data;
               default:  bad = 1'b1;
            endcase
         end
         CMD_EVENT: upd = 1'b1;
         default:   ;
      endcase

      // input recompute runs on the post-write register values
      cur       = (out_in & dir_in) | ~dir_in;
      rise      = ~inp_ff & cur;
      fall      = inp_ff & ~cur;
      edge_hit  = ((pol_in & rise) | (~pol_in & fall)) & ~trig_in;
      level_hit = ((pol_in & cur) | (~pol_in & ~cur)) & trig_in;
      if (upd) begin
         inp_in = cur;
         // level bits are rebuilt each update, edge bits stick until cleared
         is_in  = (is_wr & ~trig_in) | ((edge_hit | level_hit) & ie_in);
      end else begin
         inp_in = inp_ff;
         is_in  = is_wr;
      end

      rsp.read_data   = rd;
      rsp.bad_address = bad;
      rsp.pin_levels  = dir_in & out_in & PinMask;
      rsp.irq         = |(ie_in & is_in & PinMask);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff  <= 32'd0;
         out_ff  <= 32'd0;
         inp_ff  <= 32'd0;
         ie_ff   <= 32'd0;
         is_ff   <= 32'd0;
         trig_ff <= 32'd0;
         pol_ff  <= 32'd0;
      end else if (exec) begin
         dir_ff  <= dir_in;
         out_ff  <= out_in;
         inp_ff  <= inp_in;
         ie_ff   <= ie_in;
         is_ff   <= is_in;
         trig_ff <= trig_in;
         pol_ff  <= pol_in;
      end
   end

endmodule

// File: rtl/geli_checker.sv
// Port-level checker for the GPIO interrupt register block, with its bind.
// Depends on geli_pkg and gpio_edge_level_interrupt_regs.
module geli_checker import geli_pkg::*; #(
   parameter int PIN_COUNT = 32
) (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_payload,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_payload
);

   localparam logic [31:0] PinMask = 32'((64'd1 << PIN_COUNT) - 64'd1);

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_payload))
      else $error("request beat withdrawn or changed while stalled");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response beat dropped or changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_bad_reads_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.bad_address |-> rsp_payload.read_data == 32'd0)
      else $error("invalid index returned nonzero data");

   a_pins_masked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.pin_levels & ~PinMask) == 32'd0)
      else $error("pin level driven above pin count");

endmodule

bind gpio_edge_level_interrupt_regs geli_checker #(.PIN_COUNT(PIN_COUNT)) u_geli_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

// File: sim/tb_gpio_edge_level_interrupt_regs.sv
// Testbench for gpio_edge_level_interrupt_regs: directed and random bus/pin beats,
// predicted by a register shadow class and checked beat by beat on the response side.
// Depends on geli_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb_gpio_edge_level_interrupt_regs;
   import geli_pkg::*;

   localparam int PIN_COUNT = 32;
   localparam int RANDOM_BEATS = 1825;
   localparam logic [31:0] PIN_MASK = (PIN_COUNT >= 32) ? 32'hFFFF_FFFF
                                      : ((32'd1 << PIN_COUNT) - 32'd1);
   localparam logic [1:0] CMD_NOP = 2'd3;
   localparam logic [3:0] REG_BAD_LO = 4'd7;
   localparam logic [3:0] REG_BAD_HI = 4'd15;

   // Shadow copy of the register file; predicts one response per request beat.
   class gpio_reg_shadow;
      logic [31:0] dir_r, out_r, in_r, ie_r, st_r, trig_r, pol_r;
      rsp_type     due_rsp[$];
      int          errors;

      function new();
         {dir_r, out_r, in_r, ie_r, st_r, trig_r, pol_r} = '0;
         errors = 0;
      endfunction

      // Input/status update after a write or pin event.
      function void refresh_inputs();
         logic [31:0] cur, rise, fall, edge_hit, level_hit;
         cur = (out_r & dir_r) | ~dir_r;
         rise = ~in_r & cur;
         fall = in_r & ~cur;
         edge_hit = ((pol_r & rise) | (~pol_r & fall)) & ~trig_r;
         level_hit = ((pol_r & cur) | (~pol_r & ~cur)) & trig_r;
         in_r = cur;
         st_r = st_r & ~trig_r;  // level bits are rebuilt every update
         st_r = st_r | ((edge_hit | level_hit) & ie_r);
      endfunction

      function void note_request(req_type r);
         rsp_type e;
         e = '0;
         case (r.command)
            CMD_READ: begin
               case (r.reg_index)
                  REG_DIR:  e.read_data = dir_r;
                  REG_OUT:  e.read_data = out_r;
                  REG_IN:   e.read_data = in_r;
                  REG_IE:   e.read_data = ie_r;
                  REG_IS:   e.read_data = st_r;
                  REG_TRIG: e.read_data = trig_r;
                  REG_POL:  e.read_data = pol_r;
                  default:  e.bad_address = 1'b1;
               endcase
            end
            CMD_WRITE: begin
               case (r.reg_index)
                  REG_DIR:  dir_r = r.write_data;
                  REG_OUT:  out_r = r.write_data;
                  REG_IN:   ;
                  REG_IE:   ie_r = r.write_data;
                  REG_IS:   st_r = st_r & ~r.write_data;
                  REG_TRIG: trig_r = r.write_data;
                  REG_POL:  pol_r = r.write_data;
                  default:  e.bad_address = 1'b1;
               endcase
               refresh_inputs();
            end
            CMD_EVENT: refresh_inputs();
            default: ;
         endcase
         e.pin_levels = dir_r & out_r & PIN_MASK;
         e.irq = |(ie_r & st_r & PIN_MASK);
         due_rsp.push_back(e);
      endfunction

      function void check_response(rsp_type got);
         rsp_type e;
         if (due_rsp.size() == 0) begin
            $error("response beat with no request outstanding");
            errors++;
            return;
         end
         e = due_rsp.pop_front();
         if (got.read_data !== e.read_data) begin
            $error("read_data: expected %h, got %h", e.read_data, got.read_data);
            errors++;
         end
         if (got.bad_address !== e.bad_address) begin
            $error("bad_address: expected %b, got %b", e.bad_address, got.bad_address);
            errors++;
         end
         if (got.pin_levels !== e.pin_levels) begin
            $error("pin_levels: expected %h, got %h", e.pin_levels, got.pin_levels);
            errors++;
         end
         if (got.irq !== e.irq) begin
            $error("irq: expected %b, got %b", e.irq, got.irq);
            errors++;
         end
      endfunction

      function int pending();
         return due_rsp.size();
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;

   bit bursty = 1'b1;
   int stall_left = 0;
   gpio_reg_shadow shadow;

   gpio_edge_level_interrupt_regs #(.PIN_COUNT(PIN_COUNT)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always #5 clock = ~clock;

   initial shadow = new();

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) shadow.note_request(req_payload);
         if (rsp_valid && rsp_ready) shadow.check_response(rsp_payload);
      end
   end

   // Response-side backpressure in short bursts.
   always @(negedge clock) begin
      if (reset || !bursty) begin
         rsp_ready = 1'b1;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_ready = 1'b0;
         stall_left--;
      end else if ($urandom_range(0, 4) == 0) begin
         rsp_ready = 1'b0;
         stall_left = $urandom_range(1, 3) - 1;
      end else begin
         rsp_ready = 1'b1;
      end
   end

   function automatic req_type beat(logic [1:0] cmd, logic [3:0] idx, logic [31:0] data);
      req_type r;
      r.command = cmd;
      r.reg_index = idx;
      r.write_data = data;
      return r;
   endfunction

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 9))
         0: return 32'h0;
         1: return 32'hFFFF_FFFF;
         2: return 32'd1 << $urandom_range(0, 31);
         3: return ~(32'd1 << $urandom_range(0, 31));
         default: return $urandom;
      endcase
   endfunction

   // Mostly valid registers, writes weighted to move pins and arm interrupts.
   function automatic req_type rand_beat();
      logic [1:0] cmd;
      logic [3:0] idx;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) cmd = CMD_WRITE;
      else if (pick < 78) cmd = CMD_READ;
      else if (pick < 95) cmd = CMD_EVENT;
      else cmd = CMD_NOP;
      if ($urandom_range(0, 9) == 0) idx = 4'($urandom_range(REG_BAD_LO, REG_BAD_HI));
      else idx = 4'($urandom_range(REG_DIR, REG_POL));
      return beat(cmd, idx, rand_word());
   endfunction

   task automatic send_beat(req_type r);
      if (bursty && $urandom_range(0, 3) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_payload = r;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic drain(int limit);
      int n;
      n = 0;
      req_valid = 1'b0;
      while (shadow.pending() > 0 && n < limit) begin
         @(negedge clock);
         n++;
      end
   endtask

   initial begin
      req_type directed[$];
      directed = '{
         beat(CMD_READ,  REG_IN,     32'h0),
         beat(CMD_READ,  REG_BAD_HI, 32'h0),
         beat(CMD_NOP,   4'd9,       32'hFFFF_FFFF),
         beat(CMD_WRITE, REG_IE,     32'hFFFF_FFFF),
         beat(CMD_WRITE, REG_POL,    32'h0000_FFFF),
         beat(CMD_WRITE, REG_OUT,    32'hFFFF_FFFF),
         beat(CMD_WRITE, REG_DIR,    32'h00FF_00FF),
         beat(CMD_WRITE, REG_OUT,    32'h0),          // falling edges
         beat(CMD_READ,  REG_IS,     32'h0),
         beat(CMD_WRITE, REG_OUT,    32'hFFFF_FFFF),  // rising edges
         beat(CMD_READ,  REG_IS,     32'h0),
         beat(CMD_WRITE, REG_IS,     32'h0000_00FF),
         beat(CMD_WRITE, REG_TRIG,   32'hF0F0_F0F0),
         beat(CMD_EVENT, REG_BAD_HI, 32'hFFFF_FFFF),
         beat(CMD_WRITE, REG_IE,     32'h0000_FFFF),  // disabled edge bits keep status
         beat(CMD_READ,  REG_IS,     32'h0),
         beat(CMD_WRITE, REG_IN,     32'h1234_5678),
         beat(CMD_READ,  REG_IN,     32'h0),
         beat(CMD_WRITE, REG_BAD_LO, 32'hFFFF_FFFF),
         beat(CMD_WRITE, 4'd12,      32'hA5A5_A5A5),
         beat(CMD_READ,  REG_DIR,    32'h0),
         beat(CMD_READ,  REG_OUT,    32'h0),
         beat(CMD_READ,  REG_IE,     32'h0),
         beat(CMD_READ,  REG_TRIG,   32'h0),
         beat(CMD_READ,  REG_POL,    32'h0),
         beat(CMD_WRITE, REG_IS,     32'hFFFF_FFFF)
      };

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[i]) send_beat(directed[i]);
      drain(1000);

      for (int i = 0; i < RANDOM_BEATS; i++) begin
         bursty = (i < 1500) && ((i / 150) % 4 != 3);
         if (i == 900) drain(1000);
         send_beat(rand_beat());
      end

      drain(2000);
      repeat (10) @(negedge clock);
      if (shadow.pending() != 0) begin
         $error("%0d responses never arrived", shadow.pending());
         shadow.errors++;
      end
      if (shadow.errors == 0) begin
         $display("tb_gpio_edge_level_interrupt_regs: clean");
      end else begin
         $display("tb_gpio_edge_level_interrupt_regs: errors");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("tb_gpio_edge_level_interrupt_regs: errors");
      $finish;
   end

endmodule
